// ----- hw/rtl/vli_pkg.sv -----
// Shared types, constants and the microcode program of the vector length unit.
// No dependencies; every other file of the block refers to it by scoped names.
package vli_pkg;

  localparam int CoordWidth = 15;
  localparam int SumWidth   = 2 * CoordWidth;
  localparam int MagWidth   = 15;
  localparam int CntWidth   = $clog2(SumWidth);
  localparam int StepWidth  = 4;

  localparam logic [MagWidth-1:0] MagMax = MagWidth'(23171);

  // Seed selection masks and seeds for the Newton iteration
  localparam logic [31:0] MaskHi16 = 32'hFFFF_0000;
  localparam logic [31:0] MaskHi8  = 32'hFF00_0000;
  localparam logic [31:0] MaskMid8 = 32'h0000_FF00;
  localparam logic [31:0] SeedTop  = 32'h0000_3FFF;
  localparam logic [31:0] SeedHigh = 32'h0000_03FF;
  localparam logic [31:0] SeedMid  = 32'h0000_003F;
  localparam logic [31:0] SeedLow  = 32'h0000_0007;
  localparam logic [31:0] SeedEdge = 32'd4;

  typedef logic [StepWidth-1:0] step_t;

  localparam step_t StepLoad    = 4'd0;
  localparam step_t StepAxis    = 4'd1;
  localparam step_t StepSum     = 4'd2;
  localparam step_t StepInit    = 4'd3;
  localparam step_t StepDivG    = 4'd4;
  localparam step_t StepWaitG   = 4'd5;
  localparam step_t StepUpdate  = 4'd6;
  localparam step_t StepDivR    = 4'd7;
  localparam step_t StepWaitR   = 4'd8;
  localparam step_t StepFix     = 4'd9;
  localparam step_t StepWaitOut = 4'd10;
  localparam step_t StepEmit    = 4'd11;

  typedef enum logic [3:0] {
    OpNop,
    OpLoad,
    OpAxis,
    OpSum,
    OpInit,
    OpDivGuess,
    OpDivRes,
    OpUpdate,
    OpFix,
    OpEmit
  } op_e;

  typedef enum logic [2:0] {
    CondNone,
    CondAlways,
    CondNoInput,
    CondAxis,
    CondDivBusy,
    CondShrink,
    CondOutFull
  } cond_e;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    step_t target;
  } ctl_t;

  typedef struct packed {
    logic axis;
    logic div_busy;
    logic shrink;
    logic out_full;
  } status_t;

  // Microcode: take the jump when the condition holds, else advance by one
  function automatic ctl_t ucode(input step_t pc);
    ctl_t w;
    case (pc)
      StepLoad:    w = '{op: OpLoad,     cond: CondNoInput, target: StepLoad};
      StepAxis:    w = '{op: OpAxis,     cond: CondAxis,    target: StepWaitOut};
      StepSum:     w = '{op: OpSum,      cond: CondNone,    target: StepLoad};
      StepInit:    w = '{op: OpInit,     cond: CondNone,    target: StepLoad};
      StepDivG:    w = '{op: OpDivGuess, cond: CondNone,    target: StepLoad};
      StepWaitG:   w = '{op: OpNop,      cond: CondDivBusy, target: StepWaitG};
      StepUpdate:  w = '{op: OpUpdate,   cond: CondShrink,  target: StepDivG};
      StepDivR:    w = '{op: OpDivRes,   cond: CondNone,    target: StepLoad};
      StepWaitR:   w = '{op: OpNop,      cond: CondDivBusy, target: StepWaitR};
      StepFix:     w = '{op: OpFix,      cond: CondNone,    target: StepLoad};
      StepWaitOut: w = '{op: OpNop,      cond: CondOutFull, target: StepWaitOut};
      StepEmit:    w = '{op: OpEmit,     cond: CondAlways,  target: StepLoad};
      default:     w = '{op: OpNop,      cond: CondAlways,  target: StepLoad};
    endcase
    return w;
  endfunction

endpackage

// ----- hw/rtl/vli_if.sv -----
// Valid/ready channel interfaces for the vector length unit.
// Depends on vli_pkg for the payload widths.
interface vli_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [vli_pkg::CoordWidth-1:0]  vec_x;
  logic signed [vli_pkg::CoordWidth-1:0]  vec_y;

  modport source (output valid, output vec_x, output vec_y, input ready);
  modport sink   (input valid, input vec_x, input vec_y, output ready);
endinterface

interface vli_out_if;
  logic                          valid;
  logic                          ready;
  logic [vli_pkg::MagWidth-1:0]  magnitude;

  modport source (output valid, output magnitude, input ready);
  modport sink   (input valid, input magnitude, output ready);
endinterface

// ----- hw/rtl/vli_div.sv -----
// Restoring divider, one quotient bit per cycle, SumWidth quotient bits per division.
// Depends on vli_pkg.
module vli_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [vli_pkg::SumWidth-1:0] dividend_i,
  input  logic [vli_pkg::SumWidth-1:0] divisor_i,
  output logic                         busy_o,
  output logic [vli_pkg::SumWidth-1:0] quot_o,
  output logic [vli_pkg::SumWidth-1:0] rem_o
);
  localparam int SW = vli_pkg::SumWidth;

  logic                          busy_q, busy_d;
  logic [vli_pkg::CntWidth-1:0]  cnt_q, cnt_d;
  logic [SW-1:0]                 quot_q, quot_d;
  logic [SW-1:0]                 rem_q, rem_d;
  logic [SW-1:0]                 dvs_q, dvs_d;
  logic [SW:0]                   shifted;
  logic [SW:0]                   diff;
  logic                          fits;

  assign shifted = {rem_q, quot_q[SW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = vli_pkg::CntWidth'(SW - 1);
      quot_d = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d  = fits ? diff[SW-1:0] : shifted[SW-1:0];
      quot_d = {quot_q[SW-2:0], fits};
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    dvs_q  <= dvs_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

// ----- hw/rtl/vli_dp.sv -----
// Datapath of the vector length unit: operand registers, shared squarer,
// Newton update and output register. Depends on vli_pkg and vli_div.
module vli_dp (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  vli_pkg::ctl_t                         ctl_i,
  input  logic signed [vli_pkg::CoordWidth-1:0] vec_x_i,
  input  logic signed [vli_pkg::CoordWidth-1:0] vec_y_i,
  input  logic                                  out_ready_i,
  output logic                                  out_valid_o,
  output logic [vli_pkg::MagWidth-1:0]          magnitude_o,
  output vli_pkg::status_t                      status_o
);
  localparam int CW = vli_pkg::CoordWidth;
  localparam int SW = vli_pkg::SumWidth;

  logic [CW-1:0] ax_q, ax_d, ay_q, ay_d;
  logic [SW-1:0] acc_q, acc_d, s_q, s_d, guess_q, guess_d, res_q, res_d;
  logic [vli_pkg::MagWidth-1:0] mag_q, mag_d;
  logic          out_valid_q, out_valid_d;

  logic [CW-1:0] abs_x, abs_y, sq_op;
  logic [SW-1:0] prod;
  logic [31:0]   s_wide;
  logic [SW-1:0] seed;
  logic [SW:0]   t_sum, new_guess;
  logic          shrink;
  logic          axis;
  logic          div_start;
  logic [SW-1:0] div_dvs, quot, rem;
  logic          div_busy;

  // Magnitude of a two's complement coordinate; the most negative value maps
  // to its positive counterpart, which still fits the unsigned width
  assign abs_x = vec_x_i[CW-1] ? CW'(~vec_x_i + 1'b1) : CW'(vec_x_i);
  assign abs_y = vec_y_i[CW-1] ? CW'(~vec_y_i + 1'b1) : CW'(vec_y_i);

  assign sq_op = (ctl_i.op == vli_pkg::OpSum) ? ay_q : ax_q;
  assign prod  = SW'(sq_op) * SW'(sq_op);
  assign axis  = (ax_q == '0) || (ay_q == '0);

  // Seed from the magnitude of the sum of squares
  assign s_wide = 32'(s_q);
  always_comb begin
    if ((s_wide & vli_pkg::MaskHi16) != '0) begin
      seed = ((s_wide & vli_pkg::MaskHi8) != '0) ? SW'(vli_pkg::SeedTop)
                                                   : SW'(vli_pkg::SeedHigh);
    end else if ((s_wide & vli_pkg::MaskMid8) != '0) begin
      seed = SW'(vli_pkg::SeedMid);
    end else begin
      seed = (s_wide > vli_pkg::SeedEdge) ? SW'(vli_pkg::SeedLow) : s_q;
    end
  end

  // Candidate is ceil((s / g + g) / 2)
  assign t_sum     = {1'b0, quot} + {1'b0, guess_q};
  assign new_guess = (SW + 1)'(t_sum[SW:1]) + (SW + 1)'(t_sum[0]);
  assign shrink    = {1'b0, res_q} > new_guess;

  assign div_start = (ctl_i.op == vli_pkg::OpDivGuess) || (ctl_i.op == vli_pkg::OpDivRes);
  assign div_dvs   = (ctl_i.op == vli_pkg::OpDivRes) ? res_q : guess_q;

  vli_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (s_q),
    .divisor_i  (div_dvs),
    .busy_o     (div_busy),
    .quot_o     (quot),
    .rem_o      (rem)
  );

  always_comb begin
    ax_d        = ax_q;
    ay_d        = ay_q;
    acc_d       = acc_q;
    s_d         = s_q;
    guess_d     = guess_q;
    res_d       = res_q;
    mag_d       = mag_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (ctl_i.op)
      vli_pkg::OpLoad: begin
        ax_d = abs_x;
        ay_d = abs_y;
      end
      vli_pkg::OpAxis: begin
        if (axis) begin
          res_d = (ay_q == '0) ? SW'(ax_q) : SW'(ay_q);
        end else begin
          acc_d = prod;
        end
      end
      vli_pkg::OpSum: begin
        s_d = acc_q + prod;
      end
      vli_pkg::OpInit: begin
        res_d   = s_q;
        guess_d = seed;
      end
      vli_pkg::OpUpdate: begin
        if (shrink) begin
          res_d   = new_guess[SW-1:0];
          guess_d = new_guess[SW-1:0];
        end
      end
      vli_pkg::OpFix: begin
        // Step down when s is exactly r * (r - 1)
        if ((quot == res_q - 1'b1) && (rem == '0)) begin
          res_d = res_q - 1'b1;
        end
      end
      vli_pkg::OpEmit: begin
        mag_d       = res_q[vli_pkg::MagWidth-1:0];
        out_valid_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    acc_q   <= acc_d;
    s_q     <= s_d;
    guess_q <= guess_d;
    res_q   <= res_d;
    mag_q   <= mag_d;
  end

  assign out_valid_o       = out_valid_q;
  assign magnitude_o       = mag_q;
  assign status_o.axis     = axis;
  assign status_o.div_busy = div_busy;
  assign status_o.shrink   = shrink;
  assign status_o.out_full = out_valid_q && !out_ready_i;

endmodule

// ----- hw/rtl/vli_seq.sv -----
// Microcode sequencer: step counter, program ROM lookup and conditional jumps.
// Depends on vli_pkg.
module vli_seq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  vli_pkg::status_t status_i,
  output vli_pkg::ctl_t    ctl_o
);
  vli_pkg::step_t pc_q, pc_d;
  vli_pkg::ctl_t  ctl;
  logic           take;

  assign ctl = vli_pkg::ucode(pc_q);

  always_comb begin
    case (ctl.cond)
      vli_pkg::CondNone:    take = 1'b0;
      vli_pkg::CondAlways:  take = 1'b1;
      vli_pkg::CondNoInput: take = !in_valid_i;
      vli_pkg::CondAxis:    take = status_i.axis;
      vli_pkg::CondDivBusy: take = status_i.div_busy;
      vli_pkg::CondShrink:  take = status_i.shrink;
      vli_pkg::CondOutFull: take = status_i.out_full;
      default:              take = 1'b1;
    endcase
  end

  assign pc_d = take ? ctl.target : pc_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= vli_pkg::StepLoad;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o = ctl;

  // The Newton update and the final fix read a settled quotient
  a_update_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == vli_pkg::StepUpdate || pc_q == vli_pkg::StepFix) |-> !status_i.div_busy)
    else $error("quotient used while divider busy");

  a_accept_advances: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == vli_pkg::StepLoad && in_valid_i) |=> (pc_q == vli_pkg::StepAxis))
    else $error("accepted word did not start the program");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == vli_pkg::StepEmit) |-> !status_i.out_full)
    else $error("result written over a pending word");

  a_div_started: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q == vli_pkg::StepDivG || pc_q == vli_pkg::StepDivR) |=> status_i.div_busy)
    else $error("divider did not start");

endmodule

// ----- hw/rtl/vector_length_isqrt.sv -----
// Integer length of a signed 2-D vector, driven by a microcoded sequencer.
// A word with either coordinate zero takes a shortcut past the Newton iterations; otherwise
// each Newton iteration runs one division on the bit-serial divider. A word is accepted
// only at the load step, so a new word waits until the previous one is through the
// program. A new word is accepted while a finished result waits.
// Reset (async, active low) returns the program to its load step and empties the output.
module vector_length_isqrt (
  input  logic      clk_i,
  input  logic      rst_ni,
  vli_in_if.sink    in_i,
  vli_out_if.source out_o
);

  vli_pkg::ctl_t    ctl;
  vli_pkg::status_t status;

  // The sequencer sits at the load step and holds there until a word arrives;
  // ready is raised only by that step's opcode
  vli_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .status_i   (status),
    .ctl_o      (ctl)
  );

  // Datapath: absolute values, sum of squares through one shared squarer,
  // seed choice, Newton update around the divider, exact-product fix,
  // and the output register that parts the result from the next word
  vli_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .vec_x_i     (in_i.vec_x),
    .vec_y_i     (in_i.vec_y),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .magnitude_o (out_o.magnitude),
    .status_o    (status)
  );

  assign in_i.ready = (ctl.op == vli_pkg::OpLoad);

endmodule

// ----- verif/tb_top.sv -----
// Self-checking bench for vector_length_isqrt: random and corner vectors in, lengths checked.
// Depends on vli_pkg, the vli_in_if / vli_out_if channels and the vector_length_isqrt RTL.
`timescale 1ns / 1ps

class magnitude_scoreboard;
  typedef logic signed [vli_pkg::CoordWidth-1:0] coord_t;
  typedef logic [vli_pkg::MagWidth-1:0] mag_t;

  mag_t length_q[$];
  int   errors;

  function new();
    errors = 0;
  endfunction

  // Absolute value of a two's complement coordinate, widened so -16384 survives
  static function logic [31:0] coord_abs(coord_t c);
    logic [31:0] raw;
    raw = 32'(unsigned'(c));
    if (c[vli_pkg::CoordWidth-1]) begin
      return (32'd1 << vli_pkg::CoordWidth) - raw;
    end
    return raw;
  endfunction

  static function logic [31:0] newton_root(logic [31:0] s);
    logic [31:0] guess;
    logic [31:0] root;
    logic [31:0] t;
    bit          done;
    if (s == 32'd0) begin
      return 32'd0;
    end
    if ((s & 32'hFFFF_0000) != 32'd0) begin
      guess = ((s & 32'hFF00_0000) != 32'd0) ? 32'h3FFF : 32'h3FF;
    end else if ((s & 32'h0000_FF00) != 32'd0) begin
      guess = 32'h3F;
    end else begin
      guess = (s > 32'd4) ? 32'd7 : s;
    end
    root = s;
    done = 1'b0;
    while (!done) begin
      t     = s / guess + guess;
      guess = (t >> 1) + (t & 32'd1);
      if (root > guess) begin
        root = guess;
      end else begin
        // s == r*(r-1) rounds up one too far
        if ((s / root == root - 32'd1) && (s % root == 32'd0)) begin
          root = root - 32'd1;
        end
        done = 1'b1;
      end
    end
    return root;
  endfunction

  static function mag_t vector_length(coord_t x, coord_t y);
    logic [31:0] ax;
    logic [31:0] ay;
    logic [31:0] m;
    ax = coord_abs(x);
    ay = coord_abs(y);
    if (ay == 32'd0) begin
      m = ax;
    end else if (ax == 32'd0) begin
      m = ay;
    end else begin
      m = newton_root(ax * ax + ay * ay);
    end
    return mag_t'(m & 32'h7FFF);
  endfunction

  function void note_vector(coord_t x, coord_t y);
    length_q.push_back(vector_length(x, y));
  endfunction

  function void check_magnitude(mag_t got);
    mag_t want;
    if (length_q.size() == 0) begin
      $error("magnitude: expected none, got %0d", got);
      errors++;
      return;
    end
    want = length_q.pop_front();
    if (got !== want) begin
      $error("magnitude: expected %0d, got %0d", want, got);
      errors++;
    end
  endfunction

  function int pending();
    return length_q.size();
  endfunction
endclass

module tb_top;

  typedef logic signed [vli_pkg::CoordWidth-1:0] coord_t;

  localparam int DirCount  = 24;
  localparam int RandCount = 1680;
  localparam int CalmCount = 150;
  localparam int HoldCycles = 2500;

  // Directed corners: axes, extremes, every seed band, r*(r-1) sums
  localparam int DirX [DirCount] = '{
    0, 5, -16384, 16383, 0, 0, 0, 1, -1, 1, 2, 4,
    9, -11, 12, 181, 182, -2896, 2897, 16383, -16384, -16384, 1, -1
  };
  localparam int DirY [DirCount] = '{
    0, 0, 0, 0, -16384, 16383, -1, 1, 1, -2, -2, 2,
    -3, 11, 12, -181, 181, 2896, 2897, 16383, -16384, 16383, -16384, -1
  };

  logic clk_i;
  logic rst_ni;

  vli_in_if  in_if ();
  vli_out_if out_if ();

  vector_length_isqrt dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  magnitude_scoreboard sb;
  int results_seen;
  bit calm;
  bit long_hold_done;

  // 12 ns clock
  initial clk_i = 1'b0;
  always #6 clk_i = ~clk_i;

  // Hold every input at a known value from time zero
  initial begin
    sb             = new();
    results_seen   = 0;
    calm           = 1'b0;
    long_hold_done = 1'b0;
    rst_ni        <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.vec_x   <= '0;
    in_if.vec_y   <= '0;
    out_if.ready  <= 1'b0;
  end

  // Sample both channels at the edge; values read here are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni && in_if.valid && in_if.ready) begin
      sb.note_vector(in_if.vec_x, in_if.vec_y);
    end
    if (rst_ni && out_if.valid && out_if.ready) begin
      sb.check_magnitude(out_if.magnitude);
      results_seen++;
    end
  end

  // Offer one word and return at the edge that accepts it.
  // An optional idle burst comes first; each step sees one assignment to valid.
  task automatic drive_vector(input coord_t x, input coord_t y);
    int gap;
    if (!calm && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.vec_x <= x;
    in_if.vec_y <= y;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Pick a random vector; bias toward the bands that exercise distinct seeds
  task automatic pick_vector(output coord_t x, output coord_t y);
    int kind;
    int sel;
    int edges [6] = '{-16384, -16383, -1, 0, 1, 16383};
    kind = $urandom_range(0, 99);
    if (kind < 10) begin
      // axis shortcut, either side zero
      sel = $urandom_range(0, 1);
      x = sel ? coord_t'($urandom) : '0;
      y = sel ? '0 : coord_t'($urandom);
    end else if (kind < 30) begin
      x = coord_t'(int'($urandom_range(0, 40)) - 20);
      y = coord_t'(int'($urandom_range(0, 40)) - 20);
    end else if (kind < 50) begin
      x = coord_t'(int'($urandom_range(0, 600)) - 300);
      y = coord_t'(int'($urandom_range(0, 600)) - 300);
    end else if (kind < 90) begin
      x = coord_t'($urandom);
      y = coord_t'($urandom);
    end else if (kind < 95) begin
      x = coord_t'(edges[$urandom_range(0, 5)]);
      y = coord_t'(edges[$urandom_range(0, 5)]);
    end else begin
      // diagonal, sign flipped at random
      x = coord_t'($urandom);
      y = $urandom_range(0, 1) ? x : -x;
    end
  endtask

  // Receiver: random ready bursts, one long hold-off to back the block up,
  // and steady ready during the calm tail of the run
  initial begin
    int gap;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      if (!long_hold_done && results_seen >= 60) begin
        long_hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 6);
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  // Reset, stimulus, drain and verdict
  initial begin
    coord_t x;
    coord_t y;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < DirCount; i++) begin
      drive_vector(coord_t'(DirX[i]), coord_t'(DirY[i]));
    end

    for (int i = 0; i < RandCount; i++) begin
      if (i == RandCount / 2) begin
        // drop valid and let every outstanding length come back
        in_if.valid <= 1'b0;
        @(posedge clk_i);
        while (sb.pending() != 0) @(posedge clk_i);
      end
      calm = (i >= RandCount - CalmCount);
      pick_vector(x, y);
      drive_vector(x, y);
    end
    in_if.valid <= 1'b0;

    // step past the accepting edge so the last word is already noted
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end

endmodule
